FILE: design/rrts_pkg.sv
// Package for the round-robin task scheduler.
// Holds request, result and run-state codes and the sequencer state type.
package rrts_pkg;

   typedef enum logic [2:0] {
      REQ_TICK   = 3'd0,
      REQ_CREATE = 3'd1,
      REQ_EXIT   = 3'd2,
      REQ_KILL   = 3'd3,
      REQ_WAIT   = 3'd4
   } req_type_type;

   typedef enum logic [2:0] {
      RC_OK      = 3'd0,
      RC_NO_TASK = 3'd1,
      RC_REFUSED = 3'd2,
      RC_FULL    = 3'd3,
      RC_BLOCKED = 3'd4
   } result_code_type;

   typedef enum logic [1:0] {
      RS_RUN   = 2'd0,
      RS_READY = 2'd1,
      RS_BLOCK = 2'd2,
      RS_DEAD  = 2'd3
   } run_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND,
      ST_DECIDE,
      ST_WAKE,
      ST_SCHED,
      ST_SCHED_END,
      ST_REMOVE,
      ST_REMOVE_END,
      ST_DONE
   } seq_state_type;

endpackage

FILE: design/round_robin_task_scheduler_unit.sv
// Round-robin task scheduler unit.
//
// Channels: req_ (req_valid/req_stall, fields req_type, req_target_pid,
// req_exit_code) carries one request word; rsp_ (rsp_valid/rsp_stall, fields
// rsp_result_code, rsp_new_pid, rsp_reaped_status, rsp_running_pid,
// rsp_switched) returns exactly one result word per request.
// A small sequencer walks the task table one slot per cycle with a single
// shared index counter: pid search, waking of waiters, circular search for
// the next runnable slot and table compaction on reap are each one pass
// over the table. An unknown request goes straight to its result word;
// create and a refused exit are settled in one decision step; a kill of
// the current task searches, wakes waiters and reschedules. The block takes
// no new request until the result word is loaded into the output register;
// it accepts the next request while that word still waits, but only one
// result is held, so a stalled receiver holds the block at its final step.
// Reset (synchronous, active high) leaves only the idle task, pid 0, running
// in slot 0, with the pid counter at zero; no clearing pass is needed.
module round_robin_task_scheduler_unit #(
   parameter int MAX_TASKS = 16,
   parameter int PID_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_type,
   input  logic [15:0]                  req_target_pid,
   input  logic signed [31:0]           req_exit_code,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_result_code,
   output logic [15:0]                  rsp_new_pid,
   output logic signed [31:0]           rsp_reaped_status,
   output logic [15:0]                  rsp_running_pid,
   output logic                         rsp_switched
);
   import rrts_pkg::*;

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   logic [PID_BITS-1:0] pid_ff   [MAX_TASKS];
   run_state_type       rs_ff    [MAX_TASKS];
   logic [31:0]         stat_ff  [MAX_TASKS];
   logic [15:0]         wpid_ff  [MAX_TASKS];

   logic [CW-1:0]       count_ff;
   logic [IW-1:0]       cur_ff;
   logic [PID_BITS-1:0] last_ff;

   seq_state_type       state_ff, state_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [2:0]          op_ff;
   logic [15:0]         tpid_ff;
   logic [31:0]         code_ff;
   logic [IW-1:0]       tslot_ff, tslot_in;
   logic                tfound_ff, tfound_in;
   logic [PID_BITS-1:0] wake_pid_ff, wake_pid_in;
   logic                wake_sched_ff, wake_sched_in;
   logic [2:0]          rc_ff, rc_in;
   logic [15:0]         npid_ff, npid_in;
   logic [31:0]         reap_ff, reap_in;
   logic                sw_ff, sw_in;
   logic [IW-1:0]       sched_cur_ff, sched_cur_in;

   logic                ovalid_ff;
   logic [2:0]          orc_ff;
   logic [15:0]         onpid_ff;
   logic [31:0]         oreap_ff;
   logic [15:0]         orun_ff;
   logic                osw_ff;

   // table write controls
   logic                wr_rs;
   logic [IW-1:0]       wr_rs_idx;
   run_state_type       wr_rs_val;
   logic                wr_rs2;
   logic [IW-1:0]       wr_rs2_idx;
   run_state_type       wr_rs2_val;
   logic                wr_stat;
   logic [IW-1:0]       wr_stat_idx;
   logic                wr_wpid;
   logic                wr_create;
   logic                wr_shift;
   logic                wr_pop;
   logic [IW-1:0]       cur_in;
   logic [CW-1:0]       count_in;
   logic [PID_BITS-1:0] last_in;
   logic                take_req;
   logic                load_out;

   logic [IW-1:0]       idx_nx;
   logic [IW-1:0]       cur_eff;
   logic                cnt_wrap;
   logic [PID_BITS-1:0] npid_calc;
   logic                pid_hit;
   logic [IW-1:0]       top_idx;

   assign cur_eff  = (CW'(cur_ff) < count_ff) ? cur_ff : '0;
   assign cnt_wrap = (CW'(idx_ff) + CW'(1)) >= count_ff;
   assign idx_nx   = cnt_wrap ? '0 : idx_ff + IW'(1);
   assign pid_hit  = (PID_BITS'(tpid_ff) == pid_ff[idx_ff]) && (PID_BITS >= 16 ||
                     tpid_ff[15:(PID_BITS < 16 ? PID_BITS : 15)] == '0 || PID_BITS >= 16);
   assign npid_calc = ((last_ff + PID_BITS'(1)) == '0) ? PID_BITS'(1) : last_ff + PID_BITS'(1);
   assign top_idx  = IW'(count_ff - CW'(1));
   assign req_stall = (state_ff != ST_IDLE);
   assign take_req  = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      tslot_in      = tslot_ff;
      tfound_in     = tfound_ff;
      wake_pid_in   = wake_pid_ff;
      wake_sched_in = wake_sched_ff;
      rc_in         = rc_ff;
      npid_in       = npid_ff;
      reap_in       = reap_ff;
      sw_in         = sw_ff;
      sched_cur_in  = sched_cur_ff;
      wr_rs = 1'b0; wr_rs_idx = '0; wr_rs_val = RS_READY;
      wr_rs2 = 1'b0; wr_rs2_idx = '0; wr_rs2_val = RS_READY;
      wr_stat = 1'b0; wr_stat_idx = '0;
      wr_wpid = 1'b0; wr_create = 1'b0; wr_shift = 1'b0; wr_pop = 1'b0;
      cur_in   = cur_ff;
      count_in = count_ff;
      last_in  = last_ff;
      load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (take_req) begin
               rc_in = RC_OK; npid_in = '0; reap_in = '0; sw_in = 1'b0;
               idx_in = '0; tfound_in = 1'b0; tslot_in = '0;
               case (req_type)
                  REQ_TICK: begin
                     state_in = ST_SCHED;
                     sched_cur_in = cur_eff;
                  end
                  REQ_CREATE: state_in = ST_DECIDE;
                  REQ_EXIT:   state_in = ST_DECIDE;
                  REQ_KILL:   state_in = ST_FIND;
                  REQ_WAIT:   state_in = ST_FIND;
                  default: begin
                     rc_in = RC_REFUSED;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_FIND: begin
            if (pid_hit) begin
               tfound_in = 1'b1;
               tslot_in  = idx_ff;
               state_in  = ST_DECIDE;
            end else if (cnt_wrap) begin
               state_in = ST_DECIDE;
            end else begin
               idx_in = idx_nx;
            end
         end
         ST_DECIDE: begin
            idx_in = '0;
            state_in = ST_DONE;
            case (op_ff)
               REQ_CREATE: begin
                  if (count_ff >= CW'(MAX_TASKS)) begin
                     rc_in = RC_FULL;
                  end else begin
                     wr_create = 1'b1;
                     npid_in   = 16'(npid_calc);
                     last_in   = npid_calc;
                     count_in  = count_ff + CW'(1);
                  end
               end
               REQ_EXIT: begin
                  if (cur_eff == '0) begin
                     rc_in = RC_REFUSED;
                  end else begin
                     wr_rs = 1'b1; wr_rs_idx = cur_eff; wr_rs_val = RS_DEAD;
                     wr_stat = 1'b1; wr_stat_idx = cur_eff;
                     wake_pid_in = pid_ff[cur_eff];
                     wake_sched_in = 1'b1;
                     state_in = ST_WAKE;
                  end
               end
               REQ_KILL: begin
                  if (!tfound_ff || rs_ff[tslot_ff] == RS_DEAD) begin
                     rc_in = RC_NO_TASK;
                  end else if (tslot_ff == '0) begin
                     rc_in = RC_REFUSED;
                  end else begin
                     wr_rs = 1'b1; wr_rs_idx = tslot_ff; wr_rs_val = RS_DEAD;
                     wr_stat = 1'b1; wr_stat_idx = tslot_ff;
                     wake_pid_in = pid_ff[tslot_ff];
                     wake_sched_in = (tslot_ff == cur_eff);
                     state_in = ST_WAKE;
                  end
               end
               default: begin
                  if (!tfound_ff) begin
                     rc_in = RC_NO_TASK;
                  end else if (rs_ff[tslot_ff] == RS_DEAD) begin
                     reap_in = stat_ff[tslot_ff];
                     if (tslot_ff != '0) begin
                        idx_in = tslot_ff;
                        state_in = ST_REMOVE;
                     end
                  end else begin
                     wr_rs = 1'b1; wr_rs_idx = cur_eff; wr_rs_val = RS_BLOCK;
                     wr_wpid = 1'b1;
                     rc_in = RC_BLOCKED;
                     sched_cur_in = cur_eff;
                     state_in = ST_SCHED;
                  end
               end
            endcase
         end
         ST_WAKE: begin
            if (rs_ff[idx_ff] == RS_BLOCK && PID_BITS'(wpid_ff[idx_ff]) == wake_pid_ff
                && (PID_BITS >= 16 || wpid_ff[idx_ff] <= 16'((1 << (PID_BITS % 16)) - 1))) begin
               wr_rs = 1'b1; wr_rs_idx = idx_ff; wr_rs_val = RS_READY;
            end
            if (cnt_wrap) begin
               idx_in = '0;
               if (wake_sched_ff) begin
                  sched_cur_in = cur_eff;
                  state_in = ST_SCHED;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               idx_in = idx_nx;
            end
         end
         ST_SCHED: begin
            // demote current, begin circular search at cur+1
            if (rs_ff[sched_cur_ff] == RS_RUN) begin
               wr_rs = 1'b1; wr_rs_idx = sched_cur_ff; wr_rs_val = RS_READY;
            end
            idx_in = sched_cur_ff;
            state_in = ST_SCHED_END;
            tfound_in = 1'b0;
         end
         ST_SCHED_END: begin
            // idx_ff walks from cur+1; tfound marks a runnable hit
            begin
               logic [IW-1:0] probe;
               probe = cnt_wrap ? '0 : idx_ff + IW'(1);
               if (rs_ff[probe] == RS_RUN || rs_ff[probe] == RS_READY ||
                   (probe == sched_cur_ff && wr_rs)) begin
                  tfound_in = 1'b1;
               end
               idx_in = probe;
               if (rs_ff[probe] == RS_RUN || rs_ff[probe] == RS_READY ||
                   probe == sched_cur_ff) begin
                  begin
                     logic [IW-1:0] nx;
                     logic          okp;
                     okp = (rs_ff[probe] == RS_RUN || rs_ff[probe] == RS_READY);
                     nx  = okp ? probe : '0;
                     if (nx == '0 && count_ff > CW'(1) && rs_ff[IW'(1)] == RS_READY)
                        nx = IW'(1);
                     if (nx == sched_cur_ff) begin
                        if (rs_ff[nx] == RS_READY) begin
                           wr_rs2 = 1'b1; wr_rs2_idx = nx; wr_rs2_val = RS_RUN;
                        end
                        cur_in = sched_cur_ff;
                        sw_in  = 1'b0;
                     end else begin
                        wr_rs2 = 1'b1; wr_rs2_idx = nx; wr_rs2_val = RS_RUN;
                        cur_in = nx;
                        sw_in  = 1'b1;
                     end
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_REMOVE: begin
            if ((CW'(idx_ff) + CW'(1)) < count_ff) begin
               wr_shift = 1'b1;
               idx_in = idx_nx;
            end else begin
               state_in = ST_REMOVE_END;
            end
         end
         ST_REMOVE_END: begin
            wr_pop = 1'b1;
            count_in = count_ff - CW'(1);
            if (cur_ff > tslot_ff && CW'(cur_ff) < count_ff)
               cur_in = cur_ff - IW'(1);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!ovalid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= CW'(1);
         cur_ff   <= '0;
         last_ff  <= '0;
         ovalid_ff <= 1'b0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            pid_ff[IW'(i)] <= '0;
            rs_ff[IW'(i)]  <= (i == 0) ? RS_RUN : RS_READY;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cur_ff   <= cur_in;
         last_ff  <= last_in;
         if (load_out)
            ovalid_ff <= 1'b1;
         else if (!rsp_stall)
            ovalid_ff <= 1'b0;
         if (wr_rs)
            rs_ff[wr_rs_idx] <= wr_rs_val;
         if (wr_rs2)
            rs_ff[wr_rs2_idx] <= wr_rs2_val;
         if (wr_create) begin
            pid_ff[count_ff[IW-1:0]] <= npid_calc;
            rs_ff[count_ff[IW-1:0]]  <= RS_READY;
         end
         if (wr_shift) begin
            pid_ff[idx_ff] <= pid_ff[idx_nx];
            rs_ff[idx_ff]  <= rs_ff[idx_nx];
         end
         if (wr_pop) begin
            pid_ff[top_idx] <= '0;
            rs_ff[top_idx]  <= RS_READY;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      tslot_ff      <= tslot_in;
      tfound_ff     <= tfound_in;
      wake_pid_ff   <= wake_pid_in;
      wake_sched_ff <= wake_sched_in;
      rc_ff         <= rc_in;
      npid_ff       <= npid_in;
      reap_ff       <= reap_in;
      sw_ff         <= sw_in;
      sched_cur_ff  <= sched_cur_in;
      if (take_req) begin
         op_ff   <= req_type;
         tpid_ff <= req_target_pid;
         code_ff <= req_exit_code;
      end
      if (wr_stat)
         stat_ff[wr_stat_idx] <= (op_ff == REQ_EXIT) ? code_ff : 32'hFFFF_FFFF;
      if (wr_wpid)
         wpid_ff[cur_eff] <= tpid_ff;
      if (wr_shift) begin
         stat_ff[idx_ff] <= stat_ff[idx_nx];
         wpid_ff[idx_ff] <= wpid_ff[idx_nx];
      end
      if (load_out) begin
         orc_ff   <= rc_ff;
         onpid_ff <= npid_ff;
         oreap_ff <= reap_ff;
         orun_ff  <= 16'(pid_ff[cur_eff]);
         osw_ff   <= sw_ff;
      end
   end

   assign rsp_valid         = ovalid_ff;
   assign rsp_result_code   = orc_ff;
   assign rsp_new_pid       = onpid_ff;
   assign rsp_reaped_status = oreap_ff;
   assign rsp_running_pid   = orun_ff;
   assign rsp_switched      = osw_ff;

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken while busy");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CW'(1)) && (count_ff <= CW'(MAX_TASKS)))
      else $error("task count out of range");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && rsp_stall) |=> (ovalid_ff && $stable(orc_ff)))
      else $error("stalled result word changed");
   a_idle_pid: assert property (@(posedge clock) disable iff (reset)
      pid_ff[0] == '0)
      else $error("idle slot pid changed");

endmodule
